// File: sv/half_grid_downsampler_macros.svh
// Assertion macros shared by the half grid downsampler modules.
`ifndef HALF_GRID_DOWNSAMPLER_MACROS_SVH
`define HALF_GRID_DOWNSAMPLER_MACROS_SVH

// Checks a property on every rising edge of aclk outside reset.
`define HGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    `HGD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/hgd_pkg.sv
// Shared types and constants of the half grid downsampler.
`default_nettype none

package hgd_pkg;

    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 2;

    typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;
    typedef logic [FRAME_HEIGHT_BITS-1:0] row_count_t;

    localparam cfg_index_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FRAME_WIDTH_BITS-1:0]  RESET_FRAME_WIDTH  = 11'd1024;
    localparam logic [FRAME_HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 16'd1024;

    // Vertical operation applied to one horizontally filtered value.
    typedef enum logic [2:0] {
        VOP_EDGE,
        VOP_STORE,
        VOP_STORE_OUT,
        VOP_ACC,
        VOP_PAIR_OUT,
        VOP_PAIR_STORE
    } vop_t;

    typedef struct packed {
        vop_t op;
        logic row_end;
        logic frame_end;
    } hgd_ctl_t;

    typedef struct packed {
        logic       width_odd;
        logic       height_odd;
        row_count_t height_last;
    } hgd_shape_t;

endpackage

`default_nettype wire

// File: sv/hgd_config.sv
// Configuration registers holding the effective frame shape.
`default_nettype none

module hgd_config #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire hgd_pkg::cfg_index_t                 cfg_index,
    input  wire logic [hgd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]             width_last,
    output hgd_pkg::hgd_shape_t                      shape,
    output logic                                     restart
);

    localparam int CB = $clog2(MAX_WIDTH);

    logic [CB-1:0]       width_last_reg;
    logic                width_odd_reg;
    logic                height_odd_reg;
    hgd_pkg::row_count_t height_last_reg;

    logic                                     wr_width;
    logic                                     wr_height;
    logic [hgd_pkg::FRAME_WIDTH_BITS-1:0]     w_in;
    logic [hgd_pkg::FRAME_HEIGHT_BITS-1:0]    h_in;

    function automatic logic [CB-1:0] width_last_of(
        input logic [hgd_pkg::FRAME_WIDTH_BITS-1:0] w
    );
        if (w == '0) begin
            return '0;
        end else if (32'(w) > 32'(MAX_WIDTH)) begin
            return CB'(MAX_WIDTH - 1);
        end
        return CB'(32'(w) - 32'd1);
    endfunction

    function automatic logic width_odd_of(
        input logic [hgd_pkg::FRAME_WIDTH_BITS-1:0] w
    );
        if (w == '0) begin
            return 1'b1;
        end else if (32'(w) > 32'(MAX_WIDTH)) begin
            return 1'((MAX_WIDTH % 2) != 0);
        end
        return w[0];
    endfunction

    assign w_in = cfg_wdata[hgd_pkg::FRAME_WIDTH_BITS-1:0];
    assign h_in = cfg_wdata[hgd_pkg::FRAME_HEIGHT_BITS-1:0];

    always_comb begin
        wr_width  = 1'b0;
        wr_height = 1'b0;
        unique case (cfg_index)
            hgd_pkg::REG_FRAME_WIDTH:  wr_width  = cfg_wr_en;
            hgd_pkg::REG_FRAME_HEIGHT: wr_height = cfg_wr_en;
            default: begin
                wr_width  = 1'b0;
                wr_height = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= width_last_of(hgd_pkg::RESET_FRAME_WIDTH);
            width_odd_reg   <= width_odd_of(hgd_pkg::RESET_FRAME_WIDTH);
            height_last_reg <= hgd_pkg::RESET_FRAME_HEIGHT - 16'd1;
            height_odd_reg  <= hgd_pkg::RESET_FRAME_HEIGHT[0];
        end else begin
            if (wr_width) begin
                width_last_reg <= width_last_of(w_in);
                width_odd_reg  <= width_odd_of(w_in);
            end
            if (wr_height) begin
                height_last_reg <= (h_in == '0) ? '0 : h_in - 16'd1;
                height_odd_reg  <= (h_in == '0) ? 1'b1 : h_in[0];
            end
        end
    end

    assign width_last        = width_last_reg;
    assign shape.width_odd   = width_odd_reg;
    assign shape.height_odd  = height_odd_reg;
    assign shape.height_last = height_last_reg;
    assign restart           = wr_width || wr_height;

endmodule

`default_nettype wire

// File: sv/hgd_hfilter.sv
// Raster position tracking, horizontal filter and the input register stage.
`default_nettype none

module hgd_hfilter #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]            s_sample,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]             width_last,
    input  wire hgd_pkg::hgd_shape_t                      shape,
    input  wire logic                                     restart,
    input  wire logic                                     s1_ready,
    output logic                                          s1_valid,
    output hgd_pkg::hgd_ctl_t                             s1_ctl,
    output logic signed [SAMPLE_BITS+1:0]                 s1_hq,
    output logic [(((MAX_WIDTH+1)/2) > 1 ? $clog2((MAX_WIDTH+1)/2) : 1)-1:0] s1_addr,
    output logic                                          rd_en,
    output logic [(((MAX_WIDTH+1)/2) > 1 ? $clog2((MAX_WIDTH+1)/2) : 1)-1:0] rd_addr
);

    `include "half_grid_downsampler_macros.svh"

    localparam int CB       = $clog2(MAX_WIDTH);
    localparam int VP_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AB       = (VP_DEPTH > 1) ? $clog2(VP_DEPTH) : 1;
    localparam int HW       = SAMPLE_BITS + 2;

    logic [CB-1:0]       col_reg, col_next;
    hgd_pkg::row_count_t row_reg, row_next;
    logic signed [HW-1:0] hp_reg, hp_next;

    logic                 s1_valid_reg, s1_valid_next;
    hgd_pkg::hgd_ctl_t    s1_ctl_reg;
    logic signed [HW-1:0] s1_hq_reg;
    logic [AB-1:0]        s1_addr_reg;

    logic                 accept;
    logic                 last_col;
    logic                 last_row;
    logic                 hv;
    logic signed [HW-1:0] hq;
    logic signed [HW-1:0] s_x1;
    logic signed [HW-1:0] s_x2;
    logic signed [HW-1:0] s_x4;
    hgd_pkg::vop_t        op;

    assign s_ready  = !s1_valid_reg || s1_ready;
    assign accept   = s_valid && s_ready;
    assign last_col = (col_reg == width_last);
    assign last_row = (row_reg == shape.height_last);

    assign s_x1 = {{2{s_sample[SAMPLE_BITS-1]}}, s_sample};
    assign s_x2 = {s_sample[SAMPLE_BITS-1], s_sample, 1'b0};
    assign s_x4 = {s_sample, 2'b00};

    always_comb begin
        hv      = 1'b0;
        hq      = s_x4;
        hp_next = hp_reg;
        if (shape.width_odd) begin
            if (col_reg == '0 || last_col) begin
                hv = 1'b1;
                hq = s_x4;
            end else if (col_reg[0]) begin
                if (32'(col_reg) >= 32'd3) begin
                    hv = 1'b1;
                    hq = hp_reg + s_x1;
                end
                hp_next = s_x1;
            end else begin
                hp_next = hp_reg + s_x2;
            end
        end else begin
            if (col_reg[0]) begin
                hv = 1'b1;
                hq = hp_reg + s_x2;
            end else begin
                hp_next = s_x2;
            end
        end
    end

    always_comb begin
        if (shape.height_odd) begin
            if (row_reg == '0 || last_row) begin
                op = hgd_pkg::VOP_EDGE;
            end else if (row_reg[0]) begin
                op = (row_reg >= 16'd3) ? hgd_pkg::VOP_STORE_OUT : hgd_pkg::VOP_STORE;
            end else begin
                op = hgd_pkg::VOP_ACC;
            end
        end else begin
            op = row_reg[0] ? hgd_pkg::VOP_PAIR_OUT : hgd_pkg::VOP_PAIR_STORE;
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 16'd1;
            end else begin
                col_next = col_reg + CB'(1);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = hv;
        end else if (s1_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            hp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (restart) begin
                hp_reg <= '0;
            end else if (accept) begin
                hp_reg <= hp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg.op        <= op;
            s1_ctl_reg.row_end   <= last_col;
            s1_ctl_reg.frame_end <= last_col && last_row;
            s1_hq_reg            <= hq;
            s1_addr_reg          <= rd_addr;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = AB'(col_reg >> 1);
    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_hq    = s1_hq_reg;
    assign s1_addr  = s1_addr_reg;

    `HGD_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_ready,
        s1_valid_reg && $stable(s1_hq_reg) && $stable(s1_addr_reg),
        "Stalled filter stage lost its contents.")
    `HGD_ASSERT(a_col_range, col_reg <= width_last, "Column position past the row end.")
    `HGD_ASSERT(a_row_range, row_reg <= shape.height_last, "Row position past the frame end.")

endmodule

`default_nettype wire

// File: sv/hgd_vfilter.sv
// Vertical filter with its line store of partial sums and the result register.
`default_nettype none

module hgd_vfilter #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s1_valid,
    input  wire hgd_pkg::hgd_ctl_t                        s1_ctl,
    input  wire logic signed [SAMPLE_BITS+1:0]            s1_hq,
    input  wire logic [(((MAX_WIDTH+1)/2) > 1 ? $clog2((MAX_WIDTH+1)/2) : 1)-1:0] s1_addr,
    input  wire logic                                     rd_en,
    input  wire logic [(((MAX_WIDTH+1)/2) > 1 ? $clog2((MAX_WIDTH+1)/2) : 1)-1:0] rd_addr,
    output logic                                          s1_ready,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic signed [SAMPLE_BITS+3:0]                 m_out_sample,
    output logic                                          m_row_end,
    output logic                                          m_frame_end
);

    `include "half_grid_downsampler_macros.svh"

    localparam int VP_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AB       = (VP_DEPTH > 1) ? $clog2(VP_DEPTH) : 1;
    localparam int OW       = SAMPLE_BITS + 4;

    logic [OW-1:0] vp_mem [VP_DEPTH];

    logic [OW-1:0]        rdata_reg;
    logic [OW-1:0]        fwd_reg;
    logic                 fwd_sel_reg;
    logic                 out_valid_reg;
    logic signed [OW-1:0] out_sample_reg;
    logic                 out_row_end_reg;
    logic                 out_frame_end_reg;

    logic                 advance;
    logic                 wr_op;
    logic                 out_op;
    logic                 wr_en;
    logic                 load_out;
    logic signed [OW-1:0] vp;
    logic signed [OW-1:0] hq_x1;
    logic signed [OW-1:0] hq_x2;
    logic signed [OW-1:0] hq_x4;
    logic signed [OW-1:0] v;
    logic signed [OW-1:0] wdata;

    assign s1_ready = !out_valid_reg || m_ready;
    assign advance  = s1_valid && s1_ready;

    assign vp    = fwd_sel_reg ? fwd_reg : rdata_reg;
    assign hq_x1 = {{2{s1_hq[SAMPLE_BITS+1]}}, s1_hq};
    assign hq_x2 = {s1_hq[SAMPLE_BITS+1], s1_hq, 1'b0};
    assign hq_x4 = {s1_hq, 2'b00};

    always_comb begin
        wr_op  = 1'b0;
        out_op = 1'b0;
        v      = hq_x4;
        wdata  = hq_x1;
        unique case (s1_ctl.op)
            hgd_pkg::VOP_EDGE: begin
                out_op = 1'b1;
                v      = hq_x4;
            end
            hgd_pkg::VOP_STORE: begin
                wr_op = 1'b1;
                wdata = hq_x1;
            end
            hgd_pkg::VOP_STORE_OUT: begin
                wr_op  = 1'b1;
                out_op = 1'b1;
                wdata  = hq_x1;
                v      = vp + hq_x1;
            end
            hgd_pkg::VOP_ACC: begin
                wr_op = 1'b1;
                wdata = vp + hq_x2;
            end
            hgd_pkg::VOP_PAIR_OUT: begin
                out_op = 1'b1;
                v      = vp + hq_x2;
            end
            hgd_pkg::VOP_PAIR_STORE: begin
                wr_op = 1'b1;
                wdata = hq_x2;
            end
            default: begin
                wr_op  = 1'b0;
                out_op = 1'b0;
            end
        endcase
    end

    assign wr_en    = advance && wr_op;
    assign load_out = advance && out_op;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vp_mem[s1_addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= vp_mem[rd_addr];
        end
    end

    // A write landing on the address read in the same cycle bypasses the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_sel_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_sel_reg <= wr_en && (s1_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_sample_reg    <= v;
            out_row_end_reg   <= s1_ctl.row_end;
            out_frame_end_reg <= s1_ctl.frame_end;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_row_end    = out_row_end_reg;
    assign m_frame_end  = out_frame_end_reg;

    `HGD_ASSERT(a_frame_end_row_end, out_valid_reg && out_frame_end_reg |-> out_row_end_reg,
        "Frame end result without row end.")
    `HGD_ASSERT(a_fwd_source, fwd_sel_reg && $past(rd_en) |-> $past(wr_en),
        "Bypass selected without a colliding write.")
    `HGD_ASSERT(a_write_and_result, wr_en && load_out |-> s1_ctl.op == hgd_pkg::VOP_STORE_OUT,
        "Store write and result together for a wrong operation.")

endmodule

`default_nettype wire

// File: sv/half_grid_downsampler.sv
// Top level of the half grid downsampler.
`default_nettype none

// Halves a raster frame of signed samples in each direction with a 1-2-1 or
// pair-mean filter and produces results with 4 fraction bits. One sample is
// taken every clock cycle while results are taken as they come; a result
// is registered first in the input register stage, where the line store
// is read, and then in the output register. Requests stall only while
// both stages hold items that the output side has not taken. The line
// store holds (MAX_WIDTH+1)/2 partial sums, needs no clearing pass after
// reset, and a write to either configuration register restarts the frame
// at its first sample.
module half_grid_downsampler #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire hgd_pkg::cfg_index_t                    cfg_index,
    input  wire logic [hgd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [SAMPLE_BITS+3:0]               m_out_sample,
    output logic                                        m_row_end,
    output logic                                        m_frame_end
);

    localparam int CB       = $clog2(MAX_WIDTH);
    localparam int VP_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AB       = (VP_DEPTH > 1) ? $clog2(VP_DEPTH) : 1;

    logic [CB-1:0]              width_last;
    hgd_pkg::hgd_shape_t        shape;
    logic                       restart;
    logic                       s1_ready;
    logic                       s1_valid;
    hgd_pkg::hgd_ctl_t          s1_ctl;
    logic signed [SAMPLE_BITS+1:0] s1_hq;
    logic [AB-1:0]              s1_addr;
    logic                       rd_en;
    logic [AB-1:0]              rd_addr;

    hgd_config #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .width_last(width_last),
        .shape     (shape),
        .restart   (restart)
    );

    hgd_hfilter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_hfilter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .width_last(width_last),
        .shape     (shape),
        .restart   (restart),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_hq     (s1_hq),
        .s1_addr   (s1_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    hgd_vfilter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_vfilter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid),
        .s1_ctl      (s1_ctl),
        .s1_hq       (s1_hq),
        .s1_addr     (s1_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_ready    (s1_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_sample(m_out_sample),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire
